// ===== hdl/multi_pattern_byte_scanner_unit_macros.svh =====
// ----------------------------------------------------------------------------
// multi pattern byte scanner assertion macros
// shared assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef MULTI_PATTERN_BYTE_SCANNER_UNIT_MACROS_SVH
`define MULTI_PATTERN_BYTE_SCANNER_UNIT_MACROS_SVH

`ifndef SYNTH
// antecedent in the same cycle implies the consequent
`define MPBS_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies the consequent in the next cycle
`define MPBS_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MPBS_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg)
`define MPBS_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif

`endif

// ===== hdl/mpbs_pkg.sv =====
// ----------------------------------------------------------------------------
// mpbs_pkg
// types and constants shared by the multi pattern byte scanner
// ----------------------------------------------------------------------------
package mpbs_pkg;

  // table geometry
  localparam int NUM_PATTERNS    = 8;
  localparam int MAX_PATTERN_LEN = 16;
  localparam int SLOT_W          = $clog2(NUM_PATTERNS);
  localparam int IDX_W           = $clog2(MAX_PATTERN_LEN);
  localparam int LEN_W           = $clog2(MAX_PATTERN_LEN + 1);
  localparam int CNT_W           = $clog2(NUM_PATTERNS + 1);
  localparam int POS_W           = 40;
  localparam int OFF_W           = 32;

  // request codes
  typedef enum logic [1:0] {
    REQ_DESC = 2'd0,
    REQ_BYTE = 2'd1,
    REQ_DATA = 2'd2,
    REQ_EOF  = 2'd3
  } req_e;

  // sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  // input item
  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  pattern_slot;
    logic [4:0]  pattern_length;
    logic        anchored;
    logic [31:0] anchor_offset;
    logic        negate;
    logic [3:0]  byte_index;
    logic [7:0]  byte_value;
  } in_t;

  // result item
  typedef struct packed {
    logic        file_matched;
    logic        exclusion_hit;
    logic        inclusion_hit;
    logic [39:0] file_length;
  } out_t;

  // one pattern row, byte 0 first
  typedef logic [MAX_PATTERN_LEN-1:0][7:0] row_t;

  // slot descriptor
  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic             anchored;
    logic             negate;
    logic [OFF_W-1:0] offset;
  } desc_t;

  // per slot compare outcome
  typedef struct packed {
    logic set_mismatch;
    logic set_found;
  } cmp_res_t;

endpackage

// ===== hdl/mpbs_slot_cmp.sv =====
// ----------------------------------------------------------------------------
// mpbs_slot_cmp
// checks one pattern row against the current file byte and recent window
// ----------------------------------------------------------------------------
module mpbs_slot_cmp import mpbs_pkg::*; (
  input  desc_t             desc,
  input  row_t              pat_row,
  input  row_t              window,
  input  logic [7:0]        cur_byte,
  input  logic [POS_W-1:0]  pos_old,
  input  logic [POS_W-1:0]  seen,
  input  logic              prev_mismatch,
  output cmp_res_t          res
);

  logic [POS_W-1:0] off_ext;
  logic [POS_W-1:0] diff;
  logic [POS_W-1:0] len_ext;
  logic             in_win;
  logic             anc_mm;
  logic             anc_last;
  logic             flt_eq;
  logic [LEN_W-1:0] rev_k;

  assign off_ext = {{(POS_W-OFF_W){1'b0}}, desc.offset};
  assign len_ext = {{(POS_W-LEN_W){1'b0}}, desc.length};
  assign diff    = pos_old - off_ext;
  assign in_win  = (pos_old >= off_ext) && (diff < len_ext);

  // anchored check at the position relative to the offset
  assign anc_mm   = (pat_row[diff[IDX_W-1:0]] != cur_byte);
  assign anc_last = (diff[LEN_W-1:0] == (desc.length - LEN_W'(1)));

  // floating check: pattern byte j against window byte length-1-j
  always_comb begin
    flt_eq = 1'b1;
    rev_k  = '0;
    for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
      rev_k = desc.length - LEN_W'(1) - LEN_W'(j);
      if (LEN_W'(j) < desc.length) begin
        if (pat_row[j] != window[rev_k[IDX_W-1:0]]) begin
          flt_eq = 1'b0;
        end
      end
    end
  end

  // combine by slot mode
  always_comb begin
    res = '0;
    if (desc.length != '0) begin
      if (desc.anchored) begin
        if (in_win) begin
          res.set_mismatch = anc_mm;
          res.set_found    = anc_last && !(prev_mismatch || anc_mm);
        end
      end else if (seen >= len_ext) begin
        res.set_found = flt_eq;
      end
    end
  end

endmodule

// ===== hdl/multi_pattern_byte_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_byte_scanner_unit
// Filters a byte stream against up to eight stored patterns. A data byte is
// accepted and shifts the recent window, then one pattern row per cycle is
// read from the pattern memory and compared, so the single read port of that
// memory sets the rate; no item is accepted until that scan has ended.
// An end of file item loads the result register and resets the per-file
// state; further items are accepted while a result waits to be taken, except
// another end of file item.
// ----------------------------------------------------------------------------
`include "multi_pattern_byte_scanner_unit_macros.svh"

module multi_pattern_byte_scanner_unit import mpbs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // pattern memory, one row per slot, byte lane writes
  row_t pat_mem [NUM_PATTERNS];
  row_t rd_row_r;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [SLOT_W-1:0] cmp_slot_r, cmp_slot_nxt;
  desc_t             desc_r [NUM_PATTERNS];
  row_t              window_r;
  logic [7:0]        byte_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  pos_old_r;
  logic [NUM_PATTERNS-1:0] found_r, found_nxt;
  logic [NUM_PATTERNS-1:0] mism_r, mism_nxt;
  logic              out_valid_r;
  out_t              out_data_r;

  logic              in_acc;
  logic              rd_en;
  logic [SLOT_W-1:0] wr_slot;
  logic              slot_ok;
  logic              idx_ok;
  logic              excl;
  logic              incl;
  logic              any_incl;
  logic [LEN_W-1:0]  len_clamp;
  cmp_res_t          cmp_res;

  assign in_acc    = in_valid && in_ready;
  assign wr_slot   = SLOT_W'(in_data.pattern_slot);
  assign slot_ok   = (int'(in_data.pattern_slot) < NUM_PATTERNS);
  assign idx_ok    = (int'(in_data.byte_index) < MAX_PATTERN_LEN);
  assign len_clamp = (int'(in_data.pattern_length) > MAX_PATTERN_LEN) ?
                     LEN_W'(MAX_PATTERN_LEN) : LEN_W'(in_data.pattern_length);

  // sequencer next state and handshake
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    rd_en        = 1'b0;
    cmp_vld_nxt  = 1'b0;
    cmp_slot_nxt = cmp_slot_r;
    in_ready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = !(out_valid_r && !out_ready && in_data.req_type == REQ_EOF);
        if (in_valid && in_ready && in_data.req_type == REQ_DATA) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (int'(cnt_r) < NUM_PATTERNS) begin
          rd_en        = 1'b1;
          cmp_vld_nxt  = 1'b1;
          cmp_slot_nxt = cnt_r[SLOT_W-1:0];
          cnt_nxt      = cnt_r + CNT_W'(1);
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_slot_r <= cmp_slot_nxt;
  end

  // pattern memory write and registered row read
  always_ff @(posedge clk) begin
    if (in_acc && in_data.req_type == REQ_BYTE && slot_ok && idx_ok) begin
      pat_mem[wr_slot][IDX_W'(in_data.byte_index)] <= in_data.byte_value;
    end
    if (rd_en) begin
      rd_row_r <= pat_mem[cnt_r[SLOT_W-1:0]];
    end
  end

  // compare the row read last cycle
  mpbs_slot_cmp u_cmp (
    .desc          (desc_r[cmp_slot_r]),
    .pat_row       (rd_row_r),
    .window        (window_r),
    .cur_byte      (byte_r),
    .pos_old       (pos_old_r),
    .seen          (pos_r),
    .prev_mismatch (mism_r[cmp_slot_r]),
    .res           (cmp_res)
  );

  // end of file summary over all slots
  always_comb begin
    excl     = 1'b0;
    incl     = 1'b0;
    any_incl = 1'b0;
    for (int s = 0; s < NUM_PATTERNS; s++) begin
      if (desc_r[s].length != '0) begin
        if (desc_r[s].negate) begin
          excl = excl | found_r[s];
        end else begin
          any_incl = 1'b1;
          incl     = incl | found_r[s];
        end
      end
    end
  end

  // per-file flags and position
  always_comb begin
    found_nxt = found_r;
    mism_nxt  = mism_r;
    pos_nxt   = pos_r;
    if (cmp_vld_r) begin
      found_nxt[cmp_slot_r] = found_r[cmp_slot_r] | cmp_res.set_found;
      mism_nxt[cmp_slot_r]  = mism_r[cmp_slot_r] | cmp_res.set_mismatch;
    end
    if (in_acc) begin
      case (in_data.req_type)
        REQ_DESC: begin
          if (slot_ok) begin
            found_nxt[wr_slot] = 1'b0;
            mism_nxt[wr_slot]  = 1'b0;
          end
        end
        REQ_DATA: begin
          if (pos_r != {POS_W{1'b1}}) begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end
        REQ_EOF: begin
          found_nxt = '0;
          mism_nxt  = '0;
          pos_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // file state and descriptor table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r  <= '0;
      mism_r   <= '0;
      pos_r    <= '0;
      window_r <= '0;
      for (int s = 0; s < NUM_PATTERNS; s++) begin
        desc_r[s] <= '0;
      end
    end else begin
      found_r <= found_nxt;
      mism_r  <= mism_nxt;
      pos_r   <= pos_nxt;
      if (in_acc && in_data.req_type == REQ_DATA) begin
        window_r <= {window_r[MAX_PATTERN_LEN-2:0], in_data.byte_value};
      end else if (in_acc && in_data.req_type == REQ_EOF) begin
        window_r <= '0;
      end
      if (in_acc && in_data.req_type == REQ_DESC && slot_ok) begin
        desc_r[wr_slot].length   <= len_clamp;
        desc_r[wr_slot].anchored <= in_data.anchored;
        desc_r[wr_slot].negate   <= in_data.negate;
        desc_r[wr_slot].offset   <= in_data.anchor_offset;
      end
    end
  end

  // current byte and its position for the scan
  always_ff @(posedge clk) begin
    if (in_acc && in_data.req_type == REQ_DATA) begin
      byte_r    <= in_data.byte_value;
      pos_old_r <= pos_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_data.req_type == REQ_EOF) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.req_type == REQ_EOF) begin
      out_data_r.file_matched  <= !excl && (!any_incl || incl);
      out_data_r.exclusion_hit <= excl;
      out_data_r.inclusion_hit <= incl;
      out_data_r.file_length   <= pos_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // assertions
  `MPBS_ASSERT_IMP(a_no_accept_in_scan, clk, rst_n, state_r == ST_SCAN, !in_ready, "item accepted during scan")
  `MPBS_ASSERT_NXT(a_data_starts_scan, clk, rst_n, in_acc && in_data.req_type == REQ_DATA, state_r == ST_SCAN && cnt_r == '0, "data byte did not start a scan")
  `MPBS_ASSERT_IMP(a_cnt_bound, clk, rst_n, state_r == ST_SCAN, int'(cnt_r) <= NUM_PATTERNS, "scan counter overran")
  `MPBS_ASSERT_IMP(a_match_vs_excl, clk, rst_n, out_valid_r, !(out_data_r.file_matched && out_data_r.exclusion_hit), "match reported with exclusion hit")

endmodule
